// ===== rtl/four_level_page_table_walker_unit_macros.svh =====
// Assertion helpers for the page table walker.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define PTW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never occurs outside reset.
`define PTW_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/ptw_pkg.sv =====
`default_nettype none

package ptw_pkg;

    localparam int ADDR_W  = 52;
    localparam int VADDR_W = 48;
    localparam int DATA_W  = 64;
    localparam int IDX_W   = 9;

    // Input request kinds
    localparam logic KIND_PROBE = 1'b0;
    localparam logic KIND_RESP  = 1'b1;

    // Output request kinds
    localparam logic OUT_READ = 1'b0;
    localparam logic OUT_DONE = 1'b1;

    // Completion status
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_FAULT = 1'b1;

    // Entry bits
    localparam int BIT_PRESENT = 0;
    localparam int BIT_LARGE   = 7;

    // Table levels
    localparam logic [1:0] LEVEL_PML4 = 2'd0;
    localparam logic [1:0] LEVEL_PDPT = 2'd1;
    localparam logic [1:0] LEVEL_PD   = 2'd2;
    localparam logic [1:0] LEVEL_PT   = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } t_state;

    typedef struct packed {
        logic                 kind;
        logic [VADDR_W-1:0]   virt_addr;
        logic [ADDR_W-1:0]    root_table;
        logic                 use_kernel_root;
        logic [DATA_W-1:0]    read_data;
    } t_in_item;

    typedef struct packed {
        logic                 out_kind;
        logic [ADDR_W-1:0]    read_addr;
        logic                 status;
        logic [DATA_W-1:0]    entry;
    } t_out_item;

    // Pick the 9-bit table index of a virtual address for one level.
    function automatic logic [IDX_W-1:0] level_index(
        input logic [VADDR_W-1:0] vaddr,
        input logic [1:0]         level
    );
        logic [IDX_W-1:0] idx;
        case (level)
            LEVEL_PML4: idx = vaddr[47:39];
            LEVEL_PDPT: idx = vaddr[38:30];
            LEVEL_PD:   idx = vaddr[29:21];
            LEVEL_PT:   idx = vaddr[20:12];
            default:    idx = '0;
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ptw_addr_unit.sv =====
`default_nettype none

// Shared entry address adder: table base plus level index times 8,
// wrapping within the physical address width.
module ptw_addr_unit #(
    parameter int PHYS_ADDR_BITS = 52
) (
    input  wire logic [ptw_pkg::ADDR_W-1:0]  i_base,
    input  wire logic [ptw_pkg::VADDR_W-1:0] i_vaddr,
    input  wire logic [1:0]                  i_level,
    output logic      [ptw_pkg::ADDR_W-1:0]  o_addr
);

    logic [ptw_pkg::IDX_W-1:0]  w_idx;
    logic [PHYS_ADDR_BITS-1:0]  w_sum;

    // Select index, scale by entry size, add to truncated base
    always_comb begin
        w_idx  = ptw_pkg::level_index(i_vaddr, i_level);
        w_sum  = i_base[PHYS_ADDR_BITS-1:0] + PHYS_ADDR_BITS'({w_idx, 3'b000});
        o_addr = (ptw_pkg::ADDR_W)'(w_sum);
    end

endmodule

`default_nettype wire

// ===== rtl/four_level_page_table_walker_unit.sv =====
// Four-level page table walker.
// Input channel (i_in_valid / o_in_stall, payload i_in) carries two kinds of
// request: a probe with a virtual address and a top table address (or the
// kernel root register), and a memory read response holding one 64-bit entry.
// Output channel (o_out_valid / i_out_stall, payload o_out) carries either a
// memory read request for the next entry address or the finished walk with
// its status and leaf entry. A probe yields the PML4 read request; each
// response yields the next read request or the final result. Probes during a
// walk and responses while idle are dropped without a result.
// The kernel root is written over i_cfg_valid / o_cfg_ready / i_cfg_data,
// always ready, and should only change while no walk is running.
// Each request is first registered, then passes through the shared
// entry address adder, which loads the output register. The next request is
// taken once the output register is empty or drained in that cycle.
// While the receiver stalls, the result holds in the output register and
// the input side stalls. Synchronous reset returns to idle with no walk
// active, an empty output register and a zero kernel root.
`default_nettype none

`include "four_level_page_table_walker_unit_macros.svh"

module four_level_page_table_walker_unit #(
    parameter int PHYS_ADDR_BITS = 52
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,

    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire ptw_pkg::t_in_item           i_in,

    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output ptw_pkg::t_out_item               o_out,

    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [ptw_pkg::ADDR_W-1:0]  i_cfg_data
);

    ptw_pkg::t_state                  r_state, n_state;
    ptw_pkg::t_in_item                r_item, n_item;
    ptw_pkg::t_out_item               r_out, n_out;
    logic                             r_out_valid, n_out_valid;
    logic                             r_active, n_active;
    logic [1:0]                       r_level, n_level;
    logic [ptw_pkg::VADDR_W-1:0]      r_vaddr, n_vaddr;
    logic [ptw_pkg::ADDR_W-1:0]       r_kernel_root;

    logic                             w_in_acc;
    logic                             w_out_acc;
    logic [ptw_pkg::ADDR_W-1:0]       w_base;
    logic [ptw_pkg::VADDR_W-1:0]      w_vaddr;
    logic [1:0]                       w_level;
    logic [ptw_pkg::ADDR_W-1:0]       w_addr;

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_acc   = r_out_valid && !i_out_stall;
    assign o_in_stall  = (r_state != ptw_pkg::ST_IDLE) || (r_out_valid && i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    // Feed the shared adder: root for probes, entry frame for responses
    always_comb begin
        if (r_item.kind == ptw_pkg::KIND_PROBE) begin
            if (r_item.use_kernel_root || (r_item.root_table == '0)) begin
                w_base = r_kernel_root;
            end else begin
                w_base = r_item.root_table;
            end
            w_vaddr = r_item.virt_addr;
            w_level = ptw_pkg::LEVEL_PML4;
        end else begin
            w_base  = {r_item.read_data[ptw_pkg::ADDR_W-1:12], 12'h000};
            w_vaddr = r_vaddr;
            w_level = r_level + 2'd1;
        end
    end

    ptw_addr_unit #(
        .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
    ) u_addr (
        .i_base  (w_base),
        .i_vaddr (w_vaddr),
        .i_level (w_level),
        .o_addr  (w_addr)
    );

    // Sequencer: next state, walk state and result
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_out       = r_out;
        n_out_valid = r_out_valid && !w_out_acc;
        n_active    = r_active;
        n_level     = r_level;
        n_vaddr     = r_vaddr;
        case (r_state)
            ptw_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_item  = i_in;
                    n_state = ptw_pkg::ST_CALC;
                end
            end
            ptw_pkg::ST_CALC: begin
                n_state = ptw_pkg::ST_IDLE;
                if (r_item.kind == ptw_pkg::KIND_PROBE) begin
                    // Start a walk unless one is running
                    if (!r_active) begin
                        n_active    = 1'b1;
                        n_level     = ptw_pkg::LEVEL_PML4;
                        n_vaddr     = r_item.virt_addr;
                        n_out_valid = 1'b1;
                        n_out       = '{out_kind: ptw_pkg::OUT_READ, read_addr: w_addr,
                                        status: ptw_pkg::STATUS_OK, entry: '0};
                    end
                end else if (r_active) begin
                    n_out_valid = 1'b1;
                    if (!r_item.read_data[ptw_pkg::BIT_PRESENT]) begin
                        // Not present: fault
                        n_active = 1'b0;
                        n_level  = ptw_pkg::LEVEL_PML4;
                        n_out    = '{out_kind: ptw_pkg::OUT_DONE, read_addr: '0,
                                     status: ptw_pkg::STATUS_FAULT, entry: '0};
                    end else if ((r_level == ptw_pkg::LEVEL_PT) ||
                                 ((r_level == ptw_pkg::LEVEL_PD) &&
                                  r_item.read_data[ptw_pkg::BIT_LARGE])) begin
                        // Leaf reached
                        n_active = 1'b0;
                        n_level  = ptw_pkg::LEVEL_PML4;
                        n_out    = '{out_kind: ptw_pkg::OUT_DONE, read_addr: '0,
                                     status: ptw_pkg::STATUS_OK,
                                     entry: r_item.read_data};
                    end else begin
                        // Descend one level
                        n_level = w_level;
                        n_out   = '{out_kind: ptw_pkg::OUT_READ, read_addr: w_addr,
                                    status: ptw_pkg::STATUS_OK, entry: '0};
                    end
                end
            end
            default: begin
                n_state = ptw_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ptw_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_active    <= 1'b0;
            r_level     <= ptw_pkg::LEVEL_PML4;
            r_vaddr     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_active    <= n_active;
            r_level     <= n_level;
            r_vaddr     <= n_vaddr;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_out  <= n_out;
    end

    // Kernel root register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_root <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_kernel_root <= i_cfg_data;
        end
    end

    `PTW_ASSERT(a_accept_then_calc, i_clk, i_rst_n, w_in_acc |=> (r_state == ptw_pkg::ST_CALC), "accepted request not processed next cycle")
    `PTW_ASSERT(a_pending_matches_walk, i_clk, i_rst_n, r_out_valid |-> ((r_out.out_kind == ptw_pkg::OUT_READ) == r_active), "pending output kind disagrees with walk state")
    `PTW_ASSERT_NEVER(a_fault_entry_zero, i_clk, i_rst_n, r_out_valid && (r_out.status == ptw_pkg::STATUS_FAULT) && (r_out.entry != '0), "fault result carries nonzero entry")
    `PTW_ASSERT(a_idle_level_zero, i_clk, i_rst_n, !r_active |-> (r_level == ptw_pkg::LEVEL_PML4), "level not cleared while idle")

endmodule

`default_nettype wire
